[rtl/cbb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the content bounding box detector.
package cbb_pkg;

  localparam int unsigned CFG_W   = 13;  // widest configuration register
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned OUT_W   = 12;  // width of each box coordinate on the port
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG_TOLERANCE = 2'd2;

  localparam logic [CFG_W-1:0]  WIDTH_RESET     = 13'd640;
  localparam logic [CFG_W-1:0]  HEIGHT_RESET    = 13'd480;
  localparam logic [CHAN_W-1:0] TOLERANCE_RESET = 8'd20;

  localparam int unsigned MIN_DIM     = 2;
  localparam int unsigned MIN_PAD     = 8;
  localparam int unsigned PAD_DIVISOR = 14;

  // red in the lowest byte, alpha in the highest
  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } cbb_pixel_t;

  // left in the lowest bits, bottom in the highest
  typedef struct packed {
    logic [OUT_W-1:0] bottom;
    logic [OUT_W-1:0] right;
    logic [OUT_W-1:0] top;
    logic [OUT_W-1:0] left;
  } cbb_box_t;

  typedef struct packed {
    logic     found;
    cbb_box_t box;
  } cbb_result_t;

endpackage

[rtl/content_bounding_box_top.sv]
`timescale 1ns / 1ps
// Top level of the content bounding box detector.
//
// RGBA pixels of a frame enter on the in_ stream in raster order, one per
// transaction. The first pixel of each frame sets the background colour; later
// pixels with nonzero alpha whose largest channel difference exceeds the
// tolerance widen the content box. On the last pixel of the frame one result
// leaves on the out_ stream: found flag in tuser, padded and clamped box in
// tdata. Frame size and tolerance are set through the cfg_ write port. The
// user writes them only while the block is idle, which is not enforced.
// Throughput: one pixel per clock unless a last pixel waits on a held result.
// Each pixel is classified and folded into the box while it sits in the input
// register; the result is registered as the frame's last pixel leaves it.
// The padding is computed from the frame size by a registered pipeline.
// Reset restores 640x480 with tolerance 20 and starts a fresh frame.
// When the result waits for out_tready, pixels still stream; only the last
// pixel of the next frame holds in the input register until the output frees.
module content_bounding_box_top #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // red, green, blue, alpha
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [47:0]                   out_tdata,  // left, top, right, bottom
  output logic                          out_tuser,  // found
  input  logic                          cfg_we,
  input  logic [cbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbb_pkg::CFG_W-1:0]     cfg_data
);
  import cbb_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_DIMENSION);
  localparam int unsigned DW    = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned CMP_W = (DW > CFG_W) ? DW : CFG_W;

  logic [CFG_W-1:0]  width_r, height_r;
  logic [CHAN_W-1:0] tol_r;

  logic              s1_valid_r, s1_valid_nxt;
  cbb_pixel_t        s1_pix_r;
  logic              s1_adv;
  logic              in_fire;

  logic              out_valid_r, out_valid_nxt;
  cbb_result_t       out_res_r;

  logic [DW-1:0]     eff_w, eff_h;
  logic [CW-1:0]     pad;
  logic              frame_end;
  cbb_result_t       result;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (CMP_W'(v) < CMP_W'(MIN_DIM))
      clamp_dim = DW'(MIN_DIM);
    else if (CMP_W'(v) > CMP_W'(MAX_DIMENSION))
      clamp_dim = DW'(MAX_DIMENSION);
    else
      clamp_dim = DW'(v);
  endfunction

  assign eff_w = clamp_dim(width_r);
  assign eff_h = clamp_dim(height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      tol_r    <= TOLERANCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_r  <= cfg_data;
        REG_FRAME_HEIGHT: height_r <= cfg_data;
        REG_BG_TOLERANCE: tol_r    <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // a frame's last pixel waits only if the previous result is still held
  assign s1_adv    = s1_valid_r && (!frame_end || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)     s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (s1_adv && frame_end) out_valid_nxt = 1'b1;
    else if (out_tready)     out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_pix_r <= cbb_pixel_t'(in_tdata);
    if (s1_adv && frame_end) out_res_r <= result;
  end

  cbb_pad_calc #(
    .DW (DW),
    .CW (CW)
  ) u_pad (
    .clk   (clk),
    .eff_w (eff_w),
    .eff_h (eff_h),
    .pad   (pad)
  );

  cbb_tracker #(
    .DW (DW),
    .CW (CW)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .pixel     (s1_pix_r),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .tolerance (tol_r),
    .pad       (pad),
    .frame_end (frame_end),
    .result    (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.box;
  assign out_tuser  = out_res_r.found;

endmodule

[rtl/cbb_pad_calc.sv]
`timescale 1ns / 1ps
// Box padding: max(8, min(width, height) / 14), pipelined reciprocal divide.
module cbb_pad_calc #(
  parameter int unsigned DW = 13,
  parameter int unsigned CW = 12
) (
  input  logic          clk,
  input  logic [DW-1:0] eff_w,
  input  logic [DW-1:0] eff_h,
  output logic [CW-1:0] pad
);
  import cbb_pkg::*;

  localparam int unsigned SH = DW + 4;
  localparam int unsigned KW = SH - 3;
  localparam int unsigned K  = (2 ** SH) / PAD_DIVISOR;
  localparam logic [KW-1:0] RECIP = KW'(K);

  logic [DW-1:0]    m_r, m_nxt;
  logic [DW-1:0]    m2_r;
  logic [DW-1:0]    q_r, q_nxt;
  logic [CW-1:0]    pad_r, pad_nxt;
  logic [DW+KW-1:0] prod;
  logic [DW+3:0]    q14;
  logic [DW+3:0]    rem;
  logic [DW-1:0]    q_fix;

  assign m_nxt = (eff_w < eff_h) ? eff_w : eff_h;
  assign prod  = (DW+KW)'(m_r) * (DW+KW)'(RECIP);
  // estimate is exact or one low
  assign q_nxt = DW'(prod[DW+KW-1:SH]);
  assign q14   = ((DW+4)'(q_r) << 4) - ((DW+4)'(q_r) << 1);
  assign rem   = (DW+4)'(m2_r) - q14;
  assign q_fix = (rem >= (DW+4)'(PAD_DIVISOR)) ? q_r + DW'(1) : q_r;
  assign pad_nxt = (q_fix < DW'(MIN_PAD)) ? CW'(MIN_PAD) : CW'(q_fix);

  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    m2_r  <= m_r;
    q_r   <= q_nxt;
    pad_r <= pad_nxt;
  end

  assign pad = pad_r;

endmodule

[rtl/cbb_tracker.sv]
`timescale 1ns / 1ps
// Frame position, background capture, content extent tracking and box evaluation.
module cbb_tracker #(
  parameter int unsigned DW = 13,
  parameter int unsigned CW = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  cbb_pkg::cbb_pixel_t         pixel,
  input  logic [DW-1:0]               eff_w,
  input  logic [DW-1:0]               eff_h,
  input  logic [cbb_pkg::CHAN_W-1:0]  tolerance,
  input  logic [CW-1:0]               pad,
  output logic                        frame_end,
  output cbb_pkg::cbb_result_t        result
);
  import cbb_pkg::*;

  localparam logic [CW-1:0] COORD_ONES = {CW{1'b1}};

  logic [CW-1:0]     column_r, column_nxt;
  logic [CW-1:0]     row_r, row_nxt;
  logic [3*CHAN_W-1:0] bg_r, bg_nxt;
  logic [CW-1:0]     min_col_r, min_col_nxt;
  logic [CW-1:0]     max_col_r, max_col_nxt;
  logic [CW-1:0]     min_row_r, min_row_nxt;
  logic [CW-1:0]     max_row_r, max_row_nxt;
  logic              any_r, any_nxt;

  logic              first_px;
  logic [CHAN_W-1:0] d_r, d_g, d_b, d_max;
  logic              content;
  logic [DW-1:0]     col_inc, row_inc;
  logic              row_end;
  logic [CW-1:0]     left, top, right, bottom;
  logic [CW:0]       right_sum, bottom_sum;
  logic [CW:0]       w_last, h_last;

  function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  assign first_px = (column_r == '0) && (row_r == '0);

  assign d_r = absdiff(pixel.red,   bg_r[3*CHAN_W-1:2*CHAN_W]);
  assign d_g = absdiff(pixel.green, bg_r[2*CHAN_W-1:CHAN_W]);
  assign d_b = absdiff(pixel.blue,  bg_r[CHAN_W-1:0]);

  always_comb begin
    d_max = d_r;
    if (d_g > d_max) d_max = d_g;
    if (d_b > d_max) d_max = d_b;
  end

  // the first pixel defines the background, so it is never content
  assign content = !first_px && (pixel.alpha != '0) && (d_max > tolerance);

  assign col_inc   = DW'(column_r) + DW'(1);
  assign row_inc   = DW'(row_r) + DW'(1);
  assign row_end   = !(col_inc < eff_w);
  assign frame_end = row_end && !(row_inc < eff_h);

  always_comb begin
    min_col_nxt = min_col_r;
    max_col_nxt = max_col_r;
    min_row_nxt = min_row_r;
    max_row_nxt = max_row_r;
    any_nxt     = any_r;
    if (content) begin
      if (column_r < min_col_r) min_col_nxt = column_r;
      if (column_r > max_col_r) max_col_nxt = column_r;
      if (row_r < min_row_r)    min_row_nxt = row_r;
      if (row_r > max_row_r)    max_row_nxt = row_r;
      any_nxt = 1'b1;
    end
    bg_nxt     = first_px ? {pixel.red, pixel.green, pixel.blue} : bg_r;
    column_nxt = row_end ? '0 : CW'(col_inc);
    row_nxt    = row_end ? CW'(row_inc) : row_r;
  end

  // padded, clamped box from the extent including this pixel
  assign w_last     = (CW+1)'(eff_w - DW'(1));
  assign h_last     = (CW+1)'(eff_h - DW'(1));
  assign right_sum  = (CW+1)'(max_col_nxt) + (CW+1)'(pad);
  assign bottom_sum = (CW+1)'(max_row_nxt) + (CW+1)'(pad);
  assign left   = (min_col_nxt > pad) ? min_col_nxt - pad : '0;
  assign top    = (min_row_nxt > pad) ? min_row_nxt - pad : '0;
  assign right  = CW'((right_sum > w_last) ? w_last : right_sum);
  assign bottom = CW'((bottom_sum > h_last) ? h_last : bottom_sum);

  always_comb begin
    result.found = any_nxt;
    if (any_nxt) begin
      result.box.left   = OUT_W'(left);
      result.box.top    = OUT_W'(top);
      result.box.right  = OUT_W'(right);
      result.box.bottom = OUT_W'(bottom);
    end else begin
      result.box = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && frame_end)) begin
      column_r  <= '0;
      row_r     <= '0;
      bg_r      <= '0;
      min_col_r <= COORD_ONES;
      max_col_r <= '0;
      min_row_r <= COORD_ONES;
      max_row_r <= '0;
      any_r     <= 1'b0;
    end else if (step) begin
      column_r  <= column_nxt;
      row_r     <= row_nxt;
      bg_r      <= bg_nxt;
      min_col_r <= min_col_nxt;
      max_col_r <= max_col_nxt;
      min_row_r <= min_row_nxt;
      max_row_r <= max_row_nxt;
      any_r     <= any_nxt;
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the content bounding box detector.
module tb_top;
  import cbb_pkg::*;

  localparam int unsigned MAX_DIM       = 4096;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;     // output stage plus pad pipeline
  localparam int unsigned RANDOM_PIXELS = 1150;
  localparam int unsigned RANDOM_FRAMES = 40;
  localparam int unsigned SMALL_BUSY    = 150_000;  // per million

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Tracks the frame the way the detector does and holds the boxes still owed.
  class box_tracker_t;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [CHAN_W-1:0] tol_reg;
    int unsigned column, row, min_col, max_col, min_row, max_row;
    bit          any_content;
    logic [23:0] bg;
    cbb_result_t pending_boxes[$];
    int unsigned frames_done;
    int unsigned errors;

    function new();
      width_reg   = WIDTH_RESET;
      height_reg  = HEIGHT_RESET;
      tol_reg     = TOLERANCE_RESET;
      frames_done = 0;
      errors      = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      column      = 0;
      row         = 0;
      bg          = '0;
      min_col     = MAX_DIM - 1;
      max_col     = 0;
      min_row     = MAX_DIM - 1;
      max_row     = 0;
      any_content = 1'b0;
    endfunction

    function int unsigned eff_dim(logic [CFG_W-1:0] v);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function int unsigned chan_diff(logic [7:0] a, logic [7:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_FRAME_WIDTH:  width_reg = v;
        REG_FRAME_HEIGHT: height_reg = v;
        REG_BG_TOLERANCE: tol_reg = v[CHAN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit at_frame_start();
      return column == 0 && row == 0;
    endfunction

    function void take_pixel(cbb_pixel_t p);
      int unsigned w, h, diff, pad;
      cbb_result_t r;
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      if (at_frame_start()) bg = {p.red, p.green, p.blue};
      diff = chan_diff(p.red, bg[23:16]);
      if (chan_diff(p.green, bg[15:8]) > diff) diff = chan_diff(p.green, bg[15:8]);
      if (chan_diff(p.blue, bg[7:0]) > diff) diff = chan_diff(p.blue, bg[7:0]);
      if (p.alpha != 0 && diff > tol_reg) begin
        if (column < min_col) min_col = column;
        if (column > max_col) max_col = column;
        if (row < min_row) min_row = row;
        if (row > max_row) max_row = row;
        any_content = 1'b1;
      end
      if (column + 1 < w) begin
        column++;
        return;
      end
      column = 0;
      if (row + 1 < h) begin
        row++;
        return;
      end
      r = '0;
      r.found = any_content;
      if (any_content) begin
        pad = ((w < h) ? w : h) / PAD_DIVISOR;
        if (pad < MIN_PAD) pad = MIN_PAD;
        r.box.left   = 12'((min_col > pad) ? min_col - pad : 0);
        r.box.top    = 12'((min_row > pad) ? min_row - pad : 0);
        r.box.right  = 12'((max_col + pad > w - 1) ? w - 1 : max_col + pad);
        r.box.bottom = 12'((max_row + pad > h - 1) ? h - 1 : max_row + pad);
      end
      pending_boxes.push_back(r);
      frames_done++;
      clear_frame();
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_box(logic found, logic [47:0] data);
      cbb_box_t    seen;
      cbb_result_t want;
      seen = data;
      if (pending_boxes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%0b box=%h",
                 $time, found, data);
        errors++;
        return;
      end
      want = pending_boxes.pop_front();
      compare_field("found", {11'b0, want.found}, {11'b0, found});
      compare_field("left", want.box.left, seen.left);
      compare_field("top", want.box.top, seen.top);
      compare_field("right", want.box.right, seen.right);
      compare_field("bottom", want.box.bottom, seen.bottom);
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [47:0]          out_tdata;
  logic                 out_tuser;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_len           = 0;
  int unsigned cycle_count        = 0;
  int unsigned random_pixels      = 0;
  box_tracker_t tracker;

  content_bounding_box_top #(.MAX_DIMENSION(MAX_DIM)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_box(out_tuser, out_tdata);
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin : receiver
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        held     = hold_len;
        hold_len = 0;
        out_tready <= 1'b0;
        repeat (held) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic cbb_pixel_t rgba(int r, int g, int b, int a);
    cbb_pixel_t p;
    p.red   = 8'(r);
    p.green = 8'(g);
    p.blue  = 8'(b);
    p.alpha = 8'(a);
    return p;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly background-like pixels around the current background colour, with
  // a share of tolerance-edge and fully random ones.
  function automatic cbb_pixel_t pick_pixel(int unsigned busy_ppm);
    cbb_pixel_t  p;
    logic [7:0]  chans[3];
    bit          busy;
    int          v;
    int unsigned c, t, i;
    p    = {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
    busy = $urandom_range(999_999) < busy_ppm;
    if (tracker.at_frame_start() || (busy && $urandom_range(1) == 0)) return p;
    chans[0] = tracker.bg[23:16];
    chans[1] = tracker.bg[15:8];
    chans[2] = tracker.bg[7:0];
    t = tracker.tol_reg;
    if (busy) begin
      // one channel right at or just past the tolerance
      c = $urandom_range(2);
      v = int'(chans[c]) + int'(t) + int'($urandom_range(1));
      if (v > 255) v = int'(chans[c]) - int'(t) - int'($urandom_range(1));
      if (v >= 0 && v <= 255) chans[c] = 8'(v);
    end else begin
      for (i = 0; i < 3; i++) begin
        v = int'(chans[i]) + int'($urandom_range(2 * t)) - int'(t);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        chans[i] = 8'(v);
      end
    end
    p.red   = chans[0];
    p.green = chans[1];
    p.blue  = chans[2];
    return p;
  endfunction

  task automatic send_pixel(cbb_pixel_t p);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_pixel(p);
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_boxes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    tracker.write_reg(idx, v);
  endtask

  // Registers change only with the block idle and the last result out.
  task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] tol);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_BG_TOLERANCE, tol);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(idle_mode_t mode, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                           logic [CFG_W-1:0] tol, int unsigned pixels,
                           int unsigned busy_ppm, int unsigned hold, bit pause_midway);
    int unsigned i;
    configure(w, h, tol);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
      IDLE_BOTH:     begin sender_idle_pct = 28; receiver_stall_pct = 28; end
      default: ;
    endcase
    hold_len = hold;
    for (i = 0; i < pixels; i++) begin
      if (pause_midway && i == pixels / 2) wait_results_done();
      send_pixel(pick_pixel(busy_ppm));
      random_pixels++;
    end
    // complete the frame so the next register write lands between frames
    while (!tracker.at_frame_start()) begin
      send_pixel(pick_pixel(busy_ppm));
      random_pixels++;
    end
  endtask

  initial begin
    int unsigned k, base_frames;
    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // 2x2: content on a far colour and one step past tolerance; alpha zero ignored
    configure(2, 2, 20);
    send_pixel(rgba(0, 0, 0, 255));
    send_pixel(rgba(255, 255, 255, 255));
    send_pixel(rgba(255, 0, 0, 0));
    send_pixel(rgba(21, 0, 0, 1));
    // nothing beyond tolerance: empty box
    send_pixel(rgba(255, 255, 255, 0));
    send_pixel(rgba(255, 255, 255, 255));
    send_pixel(rgba(235, 255, 255, 255));
    send_pixel(rgba(255, 255, 235, 128));
    // tolerance edge on each side
    send_pixel(rgba(128, 128, 128, 255));
    send_pixel(rgba(128, 149, 128, 255));
    send_pixel(rgba(107, 128, 128, 255));
    send_pixel(rgba(128, 128, 108, 255));
    // sizes below the minimum, zero tolerance
    configure(1, 0, 0);
    send_pixel(rgba(10, 20, 30, 0));
    send_pixel(rgba(10, 20, 31, 255));
    send_pixel(rgba(10, 20, 30, 255));
    send_pixel(rgba(200, 0, 255, 0));
    // full tolerance: never content
    configure(3, 2, 255);
    send_pixel(rgba(0, 0, 0, 255));
    send_pixel(rgba(255, 255, 255, 255));
    send_pixel(rgba(255, 0, 255, 255));
    send_pixel(rgba(0, 255, 0, 1));
    send_pixel(rgba(17, 99, 240, 255));
    send_pixel(rgba(255, 255, 255, 255));

    random_pixels = 0;
    base_frames   = tracker.frames_done;
    k             = 0;
    while (random_pixels < RANDOM_PIXELS || tracker.frames_done - base_frames < RANDOM_FRAMES)
    begin
      run_phase(idle_mode_t'(k % 4), CFG_W'($urandom_range(12)), CFG_W'($urandom_range(10)),
                CFG_W'(($urandom_range(3) == 0) ? ($urandom_range(1) ? 255 : 0)
                                                : $urandom_range(1, 60)),
                $urandom_range(40, 120), SMALL_BUSY, (k == 4) ? 400 : 0, k == 6);
      k++;
    end

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
